// File: rtl/fcsm_pkg.sv
// Shared types and constants for the fan calibration and speed-map block.
// Used by fcsm_ctrl, fcsm_dp and fan_calibrate_and_speed_map; no dependencies.
`default_nettype none

package fcsm_pkg;

	// request kinds on the input stream
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_MINSPD = 2'd2;
	localparam logic [1:0] KIND_TARGET = 2'd3;

	// result actions on the output stream
	localparam logic [1:0] ACT_FORCE  = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_REPORT = 2'd2;

	// configuration register byte addresses
	localparam logic [1:0] ADDR_FORCE_MASK = 2'd0;

	localparam logic [16:0] SETTLE_BAND   = 17'd50;
	localparam logic [2:0]  SETTLE_COUNT  = 3'd5;
	localparam logic [16:0] ENABLE_MARGIN = 17'd100;
	localparam logic [7:0]  FULL_PWM      = 8'h7f;
	localparam int          PWM_BITS      = 7;   // map span is 2**7 - 1
	localparam logic [2:0]  DIV_LAST      = 3'd6; // PWM_BITS quotient steps, counted from 0

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LOW,
		PH_HIGH,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_DIV,
		CS_EMIT,
		CS_REPORT
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic div_step;
		logic load_res;
		logic load_rep;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_emit;
		logic need_div;
		logic need_report;
		logic div_last;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/fan_calibrate_and_speed_map.sv
// Fan calibration and speed-to-PWM map, top level: stream ports, APB register, assertions.
// m_tvalid rises once the taken request has moved the controller from idle into its emit
// state and the output register is loaded; a mapped speed write first passes through the
// bit-serial divider state; a report follows its restore. Requests are taken one at a time
// and only when idle; the restoring divider (one quotient bit a cycle) sets the worst case.
// Reset (arst_n low) clears all calibration state, the force mask and the output valid.
`default_nettype none

module fan_calibrate_and_speed_map (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // tach_rpm[15:0], saved_force_pwm[23:16],
	                                   // speed_code[39:24], key_fan_index[42:40], zero pad
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // pwm_value[7:0], max_fpe2[23:8], min_fpe2[39:24],
	                                   // control_enabled[40], zero pad
	output logic [1:0]       m_tuser,  // action[1:0]
	output logic             m_tlast,  // last_result
	// APB register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	fcsm_pkg::cmd_t  cmd;
	fcsm_pkg::stat_t stat;
	logic [7:0]      force_mask_q;
	logic [7:0]      pwm_value;
	logic [15:0]     max_fpe2, min_fpe2;
	logic            control_enabled;

	// Register file: just the per-fan force mask. The user must write it only while idle (the
	// block does not enforce this), so the datapath reads it directly.
	assign pready = 1'b1;
	assign prdata = (paddr == fcsm_pkg::ADDR_FORCE_MASK) ? {24'd0, force_mask_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_mask_q <= '0;
		end else if (psel && penable && pwrite && pready &&
				paddr == fcsm_pkg::ADDR_FORCE_MASK) begin
			force_mask_q <= pwdata[7:0];
		end
	end

	// Controller: takes one request at a time, steps the divider, and loads the
	// output register once it is free (so a new request can be taken while a
	// result still waits downstream).
	fcsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: settle detection, calibration registers, speed map and output register.
	fcsm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.kind            (s_tuser),
		.tach_rpm        (s_tdata[15:0]),
		.saved_force_pwm (s_tdata[23:16]),
		.speed_code      (s_tdata[39:24]),
		.key_fan_index   (s_tdata[42:40]),
		.force_mask      (force_mask_q),
		.action          (m_tuser),
		.pwm_value       (pwm_value),
		.max_fpe2        (max_fpe2),
		.min_fpe2        (min_fpe2),
		.control_enabled (control_enabled),
		.last_result     (m_tlast)
	);

	assign m_tdata = {7'd0, control_enabled, min_fpe2, max_fpe2, pwm_value};

	// A report always closes its request.
	a_report_last : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == fcsm_pkg::ACT_REPORT |-> m_tlast)
		else $error("calibration report without last flag");

	// The PWM restore is followed straight away by the report.
	a_restore_then_report : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == fcsm_pkg::ACT_REPORT)
		else $error("restore not followed by report");

	// No new request is taken while the first of two results is pending.
	a_no_accept_mid_pair : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request taken between restore and report");

endmodule

`default_nettype wire

// File: rtl/fcsm_ctrl.sv
// Sequencing state machine for the fan calibration block: input/output handshake
// and datapath commands. Depends on fcsm_pkg.
`default_nettype none

module fcsm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire fcsm_pkg::stat_t stat,
	output fcsm_pkg::cmd_t      cmd
);

	fcsm_pkg::ctl_state_t state_q, state_nx;
	logic                 rep_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcsm_pkg::CS_IDLE;
			rep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.accept) begin
				rep_q <= stat.need_report;
			end
			if (cmd.load_res || cmd.load_rep) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			fcsm_pkg::CS_IDLE: begin
				if (s_tvalid) begin
					if (stat.need_div) begin
						state_nx = fcsm_pkg::CS_DIV;
					end else if (stat.need_emit) begin
						state_nx = fcsm_pkg::CS_EMIT;
					end
				end
			end
			fcsm_pkg::CS_DIV: begin
				if (stat.div_last) begin
					state_nx = fcsm_pkg::CS_EMIT;
				end
			end
			fcsm_pkg::CS_EMIT: begin
				if (out_free) begin
					state_nx = rep_q ? fcsm_pkg::CS_REPORT : fcsm_pkg::CS_IDLE;
				end
			end
			fcsm_pkg::CS_REPORT: begin
				if (out_free) begin
					state_nx = fcsm_pkg::CS_IDLE;
				end
			end
			default: state_nx = fcsm_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			fcsm_pkg::CS_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			fcsm_pkg::CS_DIV:    cmd.div_step = 1'b1;
			fcsm_pkg::CS_EMIT:   cmd.load_res = out_free;
			fcsm_pkg::CS_REPORT: cmd.load_rep = out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/fcsm_dp.sv
// Datapath for the fan calibration block: calibration state, settle detection,
// restoring divider for the speed map, and the output register. Depends on fcsm_pkg.
`default_nettype none

module fcsm_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fcsm_pkg::cmd_t  cmd,
	output fcsm_pkg::stat_t      stat,
	input  wire logic [1:0]      kind,
	input  wire logic [15:0]     tach_rpm,
	input  wire logic [7:0]      saved_force_pwm,
	input  wire logic [15:0]     speed_code,
	input  wire logic [2:0]      key_fan_index,
	input  wire logic [7:0]      force_mask,
	output logic [1:0]           action,
	output logic [7:0]           pwm_value,
	output logic [15:0]          max_fpe2,
	output logic [15:0]          min_fpe2,
	output logic                 control_enabled,
	output logic                 last_result
);

	// calibration state
	fcsm_pkg::phase_t phase_q;
	logic [15:0] ref_q, min_q, max_q, init_q;
	logic [2:0]  stable_q;
	logic [7:0]  restore_q;
	logic        enabled_q;

	// pending result
	logic [1:0] res_action_q;
	logic [7:0] res_pwm_q;
	logic       res_last_q;

	// divider
	logic [15:0] rem_q, span_q;
	logic [6:0]  sh_q;
	logic [2:0]  cnt_q;

	logic        settling, in_band, settled, en_nx;
	logic [2:0]  stable_nx;
	logic [15:0] rpm, diff;
	logic [22:0] num;
	logic        below, above, write_ok;
	logic [16:0] trial;
	logic        ge;

	// signed compares of the model hold in 17 bits since both sides are 16-bit unsigned
	assign settling = (kind == fcsm_pkg::KIND_TICK) &&
		(phase_q == fcsm_pkg::PH_LOW || phase_q == fcsm_pkg::PH_HIGH);
	assign in_band = (phase_q == fcsm_pkg::PH_LOW)
		? (({1'b0, tach_rpm} + fcsm_pkg::SETTLE_BAND) > {1'b0, ref_q})
		: ({1'b0, tach_rpm} < ({1'b0, ref_q} + fcsm_pkg::SETTLE_BAND));
	assign stable_nx = in_band ? stable_q + 3'd1 : stable_q;
	assign settled   = settling && (stable_nx >= fcsm_pkg::SETTLE_COUNT);
	assign en_nx     = {1'b0, tach_rpm} > ({1'b0, init_q} + fcsm_pkg::ENABLE_MARGIN);

	// speed map: fpe2 -> rpm, clamp, then (rpm - min) * 127 / (max - min)
	assign rpm   = {2'b00, speed_code[15:2]};
	assign below = rpm < min_q;
	assign above = rpm > max_q;
	assign diff  = rpm - min_q;
	assign num   = {diff, {fcsm_pkg::PWM_BITS{1'b0}}} - {{fcsm_pkg::PWM_BITS{1'b0}}, diff};
	assign write_ok = (kind == fcsm_pkg::KIND_MINSPD || kind == fcsm_pkg::KIND_TARGET) &&
		(phase_q == fcsm_pkg::PH_DONE) && enabled_q && (max_q > min_q) &&
		(kind == fcsm_pkg::KIND_MINSPD || force_mask[key_fan_index]);

	assign stat.need_emit   = (kind == fcsm_pkg::KIND_START) || settled || write_ok;
	assign stat.need_div    = write_ok && !below && !above;
	assign stat.need_report = settled && (phase_q == fcsm_pkg::PH_HIGH);
	assign stat.div_last    = (cnt_q == fcsm_pkg::DIV_LAST);

	// one quotient bit per step; remainder stays below the span
	assign trial = {rem_q, sh_q[6]};
	assign ge    = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fcsm_pkg::PH_IDLE;
			ref_q     <= '0;
			min_q     <= '0;
			max_q     <= '0;
			init_q    <= '0;
			stable_q  <= '0;
			restore_q <= '0;
			enabled_q <= 1'b0;
		end else if (cmd.accept) begin
			if (kind == fcsm_pkg::KIND_START) begin
				init_q    <= tach_rpm;
				max_q     <= tach_rpm;
				ref_q     <= tach_rpm;
				restore_q <= saved_force_pwm;
				stable_q  <= '0;
				enabled_q <= 1'b0;
				phase_q   <= fcsm_pkg::PH_LOW;
			end else if (settling) begin
				if (phase_q == fcsm_pkg::PH_LOW) begin
					min_q <= tach_rpm;
				end else begin
					max_q <= tach_rpm;
				end
				if (!in_band) begin
					ref_q <= tach_rpm;
				end
				stable_q <= settled ? 3'd0 : stable_nx;
				if (settled) begin
					if (phase_q == fcsm_pkg::PH_LOW) begin
						phase_q <= fcsm_pkg::PH_HIGH;
					end else begin
						phase_q   <= fcsm_pkg::PH_DONE;
						enabled_q <= en_nx;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			unique case (kind)
				fcsm_pkg::KIND_START: begin
					res_action_q <= fcsm_pkg::ACT_FORCE;
					res_pwm_q    <= '0;
					res_last_q   <= 1'b1;
				end
				fcsm_pkg::KIND_TICK: begin
					res_action_q <= fcsm_pkg::ACT_FORCE;
					if (phase_q == fcsm_pkg::PH_LOW) begin
						res_pwm_q  <= fcsm_pkg::FULL_PWM;
						res_last_q <= 1'b1;
					end else begin
						res_pwm_q  <= restore_q;
						res_last_q <= 1'b0;
					end
				end
				default: begin
					res_action_q <= (kind == fcsm_pkg::KIND_MINSPD) ?
						fcsm_pkg::ACT_START : fcsm_pkg::ACT_FORCE;
					res_pwm_q  <= above ? fcsm_pkg::FULL_PWM : 8'd0;
					res_last_q <= 1'b1;
				end
			endcase
			rem_q  <= num[22:7];
			sh_q   <= num[6:0];
			span_q <= max_q - min_q;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 16'(trial - {1'b0, span_q}) : trial[15:0];
			sh_q  <= {sh_q[5:0], ge};
			cnt_q <= cnt_q + 3'd1;
			if (stat.div_last) begin
				res_pwm_q <= {1'b0, sh_q[5:0], ge};
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			action          <= res_action_q;
			pwm_value       <= res_pwm_q;
			max_fpe2        <= '0;
			min_fpe2        <= '0;
			control_enabled <= 1'b0;
			last_result     <= res_last_q;
		end else if (cmd.load_rep) begin
			action          <= fcsm_pkg::ACT_REPORT;
			pwm_value       <= '0;
			max_fpe2        <= {max_q[13:0], 2'b00};
			min_fpe2        <= enabled_q ? {min_q[13:0], 2'b00} : {init_q[13:0], 2'b00};
			control_enabled <= enabled_q;
			last_result     <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: verif/fan_calibrate_and_speed_map_tb.sv
// Self-checking testbench for fan_calibrate_and_speed_map: streams tach/write requests,
// predicts PWM writes and calibration reports in-line and compares every result.
// Depends on rtl/fcsm_pkg.sv and the RTL of the block; stands alone otherwise.
`default_nettype none

module fan_calibrate_and_speed_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcsm_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int TAIL_CYCLES = 20;   // tail for the divider to finish, with margin
	localparam int HOLD_CYCLES = 400;  // long receiver hold-off to back the block up

	// one request on the input stream
	typedef struct {
		logic [1:0]  kind;
		logic [15:0] tach;
		logic [7:0]  saved_pwm;
		logic [15:0] code;
		logic [2:0]  fan;
	} fan_req_t;

	// one result on the output stream
	typedef struct {
		logic [1:0]  action;
		logic [7:0]  pwm;
		logic [15:0] max_fpe2;
		logic [15:0] min_fpe2;
		logic        ctl_en;
		logic        last;
	} fan_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // tach_rpm[15:0], saved_force_pwm[23:16], speed_code[39:24],
	                             // key_fan_index[42:40], zero pad
	logic [1:0]  s_tuser = '0;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // pwm_value[7:0], max_fpe2[23:8], min_fpe2[39:24],
	                             // control_enabled[40], zero pad
	logic [1:0]  m_tuser;        // action[1:0]
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	fan_calibrate_and_speed_map i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stimulus and scoreboard storage
	fan_req_t pending_reqs[$];
	fan_req_t cur_req;
	fan_res_t due_results[$];
	int       n_queued = 0;
	int       n_taken = 0;
	int       n_err = 0;
	int       n_cycles = 0;
	int       send_idle_pct = 19;
	int       recv_idle_pct = 63;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	// shadow of the block's state
	logic [7:0]  force_mask_q = '0;
	phase_t      cal_phase = PH_IDLE;
	logic [15:0] ref_rpm = '0;
	int          stable_cnt = 0;
	logic [15:0] min_rpm = '0;
	logic [15:0] max_rpm = '0;
	logic [15:0] initial_rpm = '0;
	logic [7:0]  restore_pwm = '0;
	logic        ctl_en = 1'b0;

	task automatic add_result(input logic [1:0] act, input logic [7:0] pwm,
	                          input logic [15:0] mx, input logic [15:0] mn,
	                          input logic en, input logic last);
		fan_res_t r;
		r.action = act;
		r.pwm = pwm;
		r.max_fpe2 = mx;
		r.min_fpe2 = mn;
		r.ctl_en = en;
		r.last = last;
		due_results.push_back(r);
	endtask

	// linear map of an fpe2 speed onto 0..127 between the calibrated ends
	function automatic logic [7:0] speed_to_pwm(input logic [15:0] code);
		int rpm;
		rpm = int'(code >> 2);
		if (rpm < int'(min_rpm))
			return 8'd0;
		if (rpm > int'(max_rpm))
			return FULL_PWM;
		return 8'(((rpm - int'(min_rpm)) * 127) / (int'(max_rpm) - int'(min_rpm)));
	endfunction

	// advance the shadow state by one accepted request, queue what it should produce
	task automatic calibrate_and_map(input fan_req_t r);
		int          tach_i;
		int          ref_i;
		logic [15:0] mn;
		tach_i = int'(r.tach);
		ref_i = int'(ref_rpm);
		case (r.kind)
		KIND_START: begin
			initial_rpm = r.tach;
			max_rpm = r.tach;
			ref_rpm = r.tach;
			restore_pwm = r.saved_pwm;
			stable_cnt = 0;
			ctl_en = 1'b0;
			cal_phase = PH_LOW;
			add_result(ACT_FORCE, 8'd0, '0, '0, 1'b0, 1'b1);
		end
		KIND_TICK: begin
			if (cal_phase == PH_LOW) begin
				// falling speed: a drop of the band or more restarts the reference
				min_rpm = r.tach;
				if (tach_i > ref_i - int'(SETTLE_BAND))
					stable_cnt++;
				else
					ref_rpm = r.tach;
				if (stable_cnt >= int'(SETTLE_COUNT)) begin
					stable_cnt = 0;
					cal_phase = PH_HIGH;
					add_result(ACT_FORCE, FULL_PWM, '0, '0, 1'b0, 1'b1);
				end
			end else if (cal_phase == PH_HIGH) begin
				// rising speed: mirror image of the low phase
				max_rpm = r.tach;
				if (tach_i < ref_i + int'(SETTLE_BAND))
					stable_cnt++;
				else
					ref_rpm = r.tach;
				if (stable_cnt >= int'(SETTLE_COUNT)) begin
					stable_cnt = 0;
					cal_phase = PH_DONE;
					ctl_en = int'(max_rpm) > int'(initial_rpm) + int'(ENABLE_MARGIN);
					mn = ctl_en ? min_rpm : initial_rpm;
					add_result(ACT_FORCE, restore_pwm, '0, '0, 1'b0, 1'b0);
					add_result(ACT_REPORT, 8'd0, max_rpm << 2, mn << 2, ctl_en, 1'b1);
				end
			end
		end
		default: begin
			// speed writes only once a usable range has been calibrated
			if (cal_phase != PH_DONE || !ctl_en || max_rpm <= min_rpm)
				return;
			if (r.kind == KIND_MINSPD)
				add_result(ACT_START, speed_to_pwm(r.code), '0, '0, 1'b0, 1'b1);
			else if (force_mask_q[r.fan])
				add_result(ACT_FORCE, speed_to_pwm(r.code), '0, '0, 1'b0, 1'b1);
		end
		endcase
	endtask

	// request driver: holds a request until taken, random gaps between requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				calibrate_and_map(cur_req);
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_req = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {5'b0, cur_req.fan, cur_req.code, cur_req.saved_pwm, cur_req.tach};
					s_tuser <= cur_req.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off on the result side while requests keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_taken >= 60) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor: field-by-field compare against the oldest due result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					if (n_err < 10)
						$display("%0t: unexpected result action=%0d pwm=%0d tdata=%h",
						         $realtime, m_tuser, m_tdata[7:0], m_tdata);
					n_err++;
				end else begin
					fan_res_t e;
					e = due_results.pop_front();
					if (m_tuser !== e.action || m_tdata[7:0] !== e.pwm ||
					    m_tdata[23:8] !== e.max_fpe2 || m_tdata[39:24] !== e.min_fpe2 ||
					    m_tdata[40] !== e.ctl_en || m_tlast !== e.last) begin
						if (n_err < 10) begin
							$write("%0t: mismatch exp act=%0d pwm=%0d max=%h min=%h en=%b last=%b",
							       $realtime, e.action, e.pwm, e.max_fpe2, e.min_fpe2,
							       e.ctl_en, e.last);
							$display(", got act=%0d pwm=%0d max=%h min=%h en=%b last=%b",
							         m_tuser, m_tdata[7:0], m_tdata[23:8],
							         m_tdata[39:24], m_tdata[40], m_tlast);
						end
						n_err++;
					end
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_req(input logic [1:0] kind, input int tach, input int saved,
	                       input int code, input int fan);
		fan_req_t r;
		r.kind = kind;
		r.tach = 16'(tach);
		r.saved_pwm = 8'(saved);
		r.code = 16'(code);
		r.fan = 3'(fan);
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	task automatic add_noise();
		add_req(2'($urandom_range(0, 3)), $urandom_range(0, 65535), $urandom_range(0, 255),
		        $urandom_range(0, 65535), $urandom_range(0, 7));
	endtask

	// a start followed by tach ticks that settle low then high, then speed writes;
	// the settle rule is tracked locally so each phase ends where intended
	task automatic add_calibration();
		int ref_v;
		int cnt;
		int tach;
		int mn;
		int mx;
		int init;
		int rpm;
		bit cut_short;
		init = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4000);
		cut_short = ($urandom_range(0, 9) == 0);
		add_req(KIND_START, init, $urandom_range(0, 255), $urandom_range(0, 65535),
		        $urandom_range(0, 7));
		ref_v = init;
		cnt = 0;
		mn = init;
		while (cnt < int'(SETTLE_COUNT)) begin
			if ($urandom_range(0, 3) == 0)
				tach = ref_v - int'(SETTLE_BAND) - $urandom_range(0, 300);
			else
				tach = ref_v - int'(SETTLE_BAND) + 1 + $urandom_range(0, 250);
			tach = (tach < 0) ? 0 : (tach > 65535) ? 65535 : tach;
			if (tach > ref_v - int'(SETTLE_BAND))
				cnt++;
			else
				ref_v = tach;
			mn = tach;
			add_req(KIND_TICK, tach, $urandom_range(0, 255), $urandom_range(0, 65535),
			        $urandom_range(0, 7));
			// writes mid-calibration must be ignored
			if ($urandom_range(0, 7) == 0)
				add_req(2'($urandom_range(2, 3)), $urandom_range(0, 65535), 0,
				        $urandom_range(0, 65535), $urandom_range(0, 7));
			if (cut_short && $urandom_range(0, 2) == 0)
				return;
		end
		cnt = 0;
		mx = mn;
		while (cnt < int'(SETTLE_COUNT)) begin
			if ($urandom_range(0, 2) == 0)
				tach = ref_v + int'(SETTLE_BAND) + $urandom_range(0, 3000);
			else
				tach = ref_v + int'(SETTLE_BAND) - 1 - $urandom_range(0, 250);
			tach = (tach < 0) ? 0 : (tach > 65535) ? 65535 : tach;
			if (tach < ref_v + int'(SETTLE_BAND))
				cnt++;
			else
				ref_v = tach;
			mx = tach;
			add_req(KIND_TICK, tach, $urandom_range(0, 255), $urandom_range(0, 65535),
			        $urandom_range(0, 7));
		end
		repeat ($urandom_range(2, 8)) begin
			if (mx > mn && $urandom_range(0, 9) < 7) begin
				rpm = $urandom_range(mn, mx);
				rpm = (rpm > 16383) ? 16383 : rpm;
				add_req(2'($urandom_range(2, 3)), $urandom_range(0, 65535), 0,
				        (rpm << 2) | $urandom_range(0, 3), $urandom_range(0, 7));
			end else begin
				add_req(2'($urandom_range(2, 3)), $urandom_range(0, 65535), 0,
				        $urandom_range(0, 65535), $urandom_range(0, 7));
			end
		end
		// stray ticks once calibrated do nothing
		if ($urandom_range(0, 3) == 0)
			add_req(KIND_TICK, $urandom_range(0, 65535), 0, 0, 0);
	endtask

	task automatic add_random(input int upto);
		while (n_queued < upto) begin
			if ($urandom_range(0, 4) == 0)
				add_noise();
			else
				add_calibration();
		end
	endtask

	// wait until every request is taken and every result seen, then let the block settle
	task automatic wait_quiet();
		while (pending_reqs.size() != 0 || s_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_force_mask(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_FORCE_MASK;
		pwdata <= {24'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		force_mask_q = value;
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		write_force_mask(8'hff);

		// directed: writes and a tick before any calibration are dropped
		add_req(KIND_MINSPD, 0, 0, 16'h1234, 0);
		add_req(KIND_TARGET, 0, 0, 16'h1234, 7);
		add_req(KIND_TICK, 16'h0fff, 0, 0, 0);
		// full calibration: drop resets the reference but not the count; five stable samples in all
		add_req(KIND_START, 1000, 8'ha5, 0, 0);
		add_req(KIND_TICK, 1000, 0, 0, 0);
		add_req(KIND_TICK, 900, 0, 0, 0);
		add_req(KIND_TICK, 899, 0, 0, 0);
		add_req(KIND_TICK, 880, 0, 0, 0);
		add_req(KIND_TICK, 860, 0, 0, 0);
		add_req(KIND_TICK, 851, 0, 0, 0);
		// high phase: a rise resets the reference, dip still counts as stable
		add_req(KIND_TICK, 3000, 0, 0, 0);
		add_req(KIND_TICK, 3049, 0, 0, 0);
		add_req(KIND_TICK, 2000, 0, 0, 0);
		add_req(KIND_TICK, 3010, 0, 0, 0);
		add_req(KIND_TICK, 3040, 0, 0, 0);
		add_req(KIND_TICK, 3020, 0, 0, 0);
		// map: below min, above max, middle, exact ends
		add_req(KIND_MINSPD, 0, 0, 16'h0000, 0);
		add_req(KIND_MINSPD, 0, 0, 16'hffff, 0);
		add_req(KIND_TARGET, 0, 0, 1935 << 2, 7);
		add_req(KIND_TARGET, 0, 0, 851 << 2, 0);
		add_req(KIND_TARGET, 0, 0, (3020 << 2) | 3, 3);
		// restart from done, then again mid-calibration
		add_req(KIND_START, 16'hffff, 8'hff, 16'hffff, 7);
		add_req(KIND_TICK, 0, 0, 0, 0);
		add_req(KIND_START, 0, 0, 0, 0);
		add_req(KIND_TICK, 16'hffff, 8'hff, 16'hffff, 7);
		wait_quiet();

		// sender mostly busy, receiver mostly stalled
		write_force_mask(8'($urandom_range(1, 254)));
		add_random(230);
		wait_quiet();
		write_force_mask(8'h00);
		add_random(450);
		wait_quiet();

		// roles swapped
		send_idle_pct = 63;
		recv_idle_pct = 19;
		write_force_mask(8'($urandom_range(0, 255)));
		add_random(875);
		wait_quiet();

		// flat out
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_force_mask(8'hff);
		add_random(1300);
		wait_quiet();

		if (n_err == 0 && due_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
